// File: rtl/rtc_pkg.sv
// Shared types and constants for the timed RGB crossfade block.
package rtc_pkg;

   localparam int COLOUR_BITS      = 16;
   localparam int LEVEL_BITS       = 10;
   localparam int NUM_CHANNELS     = 3;
   localparam int CHAN_BITS        = 2;
   localparam int SCALE_BITS       = COLOUR_BITS + LEVEL_BITS;
   localparam logic [COLOUR_BITS-1:0] COLOUR_MAX = 16'hFFFF;
   localparam logic [LEVEL_BITS-1:0] FULL_SCALE_RESET = 10'd500;
   localparam logic [CHAN_BITS-1:0] LAST_CHANNEL = 2'd2;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef logic [COLOUR_BITS-1:0] colour_type;
   typedef logic [LEVEL_BITS-1:0]  level_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: rtl/rtc_div.sv
// Iterative restoring divider that yields a 16-bit quotient, one bit per cycle.
module rtc_div #(
   parameter int TIME_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [TIME_BITS+rtc_pkg::COLOUR_BITS-1:0] dividend,
   input  logic [TIME_BITS-1:0]                divisor,
   output rtc_pkg::colour_type                 quotient,
   output rtc_pkg::div_status_type             status
);
   import rtc_pkg::*;

   localparam int CW = $clog2(COLOUR_BITS + 1);

   logic [TIME_BITS-1:0]   rem_ff;
   logic [COLOUR_BITS-1:0] low_ff;
   logic [COLOUR_BITS-1:0] quot_ff;
   logic [TIME_BITS-1:0]   div_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;

   logic [TIME_BITS:0]     trial;
   logic [TIME_BITS:0]     trial_sub;
   logic                   qbit;

   assign trial     = {rem_ff, low_ff[COLOUR_BITS-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign qbit      = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend[TIME_BITS+COLOUR_BITS-1:COLOUR_BITS];
            low_ff  <= dividend[COLOUR_BITS-1:0];
            div_ff  <= divisor;
            quot_ff <= '0;
            cnt_ff  <= CW'(COLOUR_BITS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= qbit ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            low_ff  <= {low_ff[COLOUR_BITS-2:0], 1'b0};
            quot_ff <= {quot_ff[COLOUR_BITS-2:0], qbit};
            cnt_ff  <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/rgb_timed_crossfade_top.sv
// Top level of the timed RGB crossfade: sequencer, scaling and stream ports.
//
// Each request transfer is either a scene start (tuser 0) or a time tick
// (tuser 1). A start or a tick while a scene runs yields one response with
// three 10-bit levels; a tick while idle yields none. During a fade each
// channel is computed one after the other through a single 16-step restoring
// divider and then scaled, so the request side stays busy until all three
// levels of a fading item are done. While holding, each channel skips the
// divider and is only scaled, and the request side is likewise busy until
// the holding item is done. A tick while idle is dropped in its own cycle
// and the request side stays ready. A response still waiting in the output
// register stalls the last step until it is taken, and no request is taken
// meanwhile. The full-scale register is written through the csr channel,
// which is always ready.
module rgb_timed_crossfade_top #(
   parameter int TIME_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // prev_red, prev_green, prev_blue, next_red, next_green, next_blue,
   // scene_length, fade_length
   input  logic [119:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // red_level, green_level, blue_level, two zero bits
   output logic [31:0]  rsp_tdata,
   // in_fade
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [9:0]   csr_data
);
   import rtc_pkg::*;

   localparam int PROD_BITS = TIME_BITS + COLOUR_BITS;

   typedef enum logic [2:0] {
      IDLE,
      PRODUCT,
      DIV_START,
      DIV_WAIT,
      SCALE_MUL,
      SCALE_FIX,
      FINISH
   } state_type;

   state_type              state_ff;
   logic                   running_ff;
   level_type              full_scale_ff;
   colour_type             start_ff [NUM_CHANNELS];
   colour_type             end_ff [NUM_CHANNELS];
   level_type              level_ff [NUM_CHANNELS];
   logic [TIME_BITS-1:0]   total_ff;
   logic [TIME_BITS-1:0]   fade_ff;
   logic [TIME_BITS-1:0]   elapsed_ff;
   logic [CHAN_BITS-1:0]   ch_ff;
   logic                   neg_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   colour_type             value_ff;
   logic [SCALE_BITS-1:0]  sprod_ff;
   logic                   rsp_valid_ff;
   level_type              rsp_level_ff [NUM_CHANNELS];
   logic                   rsp_fade_ff;
   logic                   rsp_last_ff;

   logic [TIME_BITS-1:0]   req_scene;
   logic [TIME_BITS-1:0]   req_fade;
   logic                   req_accept;
   logic                   rsp_load;
   logic                   fading;
   logic [COLOUR_BITS:0]   diff;
   colour_type             mag;
   logic [PROD_BITS-1:0]   prod_in;
   colour_type             quotient;
   div_status_type         div_status;
   logic [COLOUR_BITS:0]   signed_q;
   logic [COLOUR_BITS:0]   value_in;
   logic [SCALE_BITS-1:0]  sprod_in;
   level_type              scale_q0;
   logic [COLOUR_BITS:0]   scale_rem;
   level_type              level_in;

   assign req_scene  = TIME_BITS'(req_tdata[107:96]);
   assign req_fade   = TIME_BITS'(req_tdata[119:108]);
   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == FINISH) && (!rsp_valid_ff || rsp_tready);

   assign fading  = (elapsed_ff < fade_ff);
   assign diff    = {1'b0, end_ff[ch_ff]} - {1'b0, start_ff[ch_ff]};
   assign mag     = diff[COLOUR_BITS] ? COLOUR_BITS'(-diff) : diff[COLOUR_BITS-1:0];
   assign prod_in = PROD_BITS'(elapsed_ff) * PROD_BITS'(mag);

   rtc_div #(
      .TIME_BITS(TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == DIV_START),
      .dividend (prod_ff),
      .divisor  (fade_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   assign signed_q  = neg_ff ? -{1'b0, quotient} : {1'b0, quotient};
   assign value_in  = {1'b0, start_ff[ch_ff]} + signed_q;
   assign sprod_in  = SCALE_BITS'(value_ff) * SCALE_BITS'(full_scale_ff);
   assign scale_q0  = sprod_ff[SCALE_BITS-1:COLOUR_BITS];
   assign scale_rem = {1'b0, sprod_ff[COLOUR_BITS-1:0]} + (COLOUR_BITS+1)'(scale_q0);
   assign level_in  = scale_q0 + LEVEL_BITS'(scale_rem >= {1'b0, COLOUR_MAX});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         running_ff    <= 1'b0;
         full_scale_ff <= FULL_SCALE_RESET;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         fade_ff       <= '0;
         elapsed_ff    <= '0;
         ch_ff         <= '0;
      end else begin
         if (csr_valid) begin
            full_scale_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  ch_ff <= '0;
                  if (req_tuser == KIND_START) begin
                     start_ff[0] <= req_tdata[15:0];
                     start_ff[1] <= req_tdata[31:16];
                     start_ff[2] <= req_tdata[47:32];
                     end_ff[0]   <= req_tdata[63:48];
                     end_ff[1]   <= req_tdata[79:64];
                     end_ff[2]   <= req_tdata[95:80];
                     total_ff    <= req_scene;
                     fade_ff     <= (req_fade > req_scene) ? req_scene : req_fade;
                     elapsed_ff  <= '0;
                     running_ff  <= 1'b1;
                     state_ff    <= PRODUCT;
                  end else if (running_ff) begin
                     elapsed_ff <= elapsed_ff + TIME_BITS'(1);
                     state_ff   <= PRODUCT;
                  end
               end
            end
            PRODUCT: begin
               if (fading) begin
                  prod_ff  <= prod_in;
                  neg_ff   <= diff[COLOUR_BITS];
                  state_ff <= DIV_START;
               end else begin
                  value_ff <= end_ff[ch_ff];
                  state_ff <= SCALE_MUL;
               end
            end
            DIV_START: begin
               state_ff <= DIV_WAIT;
            end
            DIV_WAIT: begin
               if (div_status.done) begin
                  value_ff <= value_in[COLOUR_BITS-1:0];
                  state_ff <= SCALE_MUL;
               end
            end
            SCALE_MUL: begin
               sprod_ff <= sprod_in;
               state_ff <= SCALE_FIX;
            end
            SCALE_FIX: begin
               level_ff[ch_ff] <= level_in;
               if (ch_ff == LAST_CHANNEL) begin
                  state_ff <= FINISH;
               end else begin
                  ch_ff    <= ch_ff + CHAN_BITS'(1);
                  state_ff <= PRODUCT;
               end
            end
            FINISH: begin
               if (rsp_load) begin
                  rsp_level_ff[0] <= level_ff[0];
                  rsp_level_ff[1] <= level_ff[1];
                  rsp_level_ff[2] <= level_ff[2];
                  rsp_fade_ff     <= fading;
                  rsp_last_ff     <= (elapsed_ff >= total_ff);
                  if (elapsed_ff >= total_ff) begin
                     running_ff <= 1'b0;
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_level_ff[2], rsp_level_ff[1], rsp_level_ff[0]};
   assign rsp_tuser  = rsp_fade_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff <= total_ff)
      else $error("elapsed count passed the scene length");

   a_fade_clamped: assert property (@(posedge clock) disable iff (reset)
      fade_ff <= total_ff)
      else $error("fade length exceeds the scene length");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == DIV_WAIT))
      else $error("divider finished outside the wait state");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == KIND_START) |=> !req_tready)
      else $error("scene start transfer did not occupy the sequencer");

endmodule
